/* src/lpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

	localparam int NUM_ROUTES_DEF = 16;
	// wide enough to count up to the largest table (511 routes)
	localparam int CNT_W = 9;
	localparam logic [5:0] MAX_PREFIX = 6'd32;

	localparam logic [2:0] ST_ADDED  = 3'd0;
	localparam logic [2:0] ST_FOUND  = 3'd1;
	localparam logic [2:0] ST_NONE   = 3'd2;
	localparam logic [2:0] ST_BADPFX = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_LOOKUP,
		OP_BADPFX,
		OP_FULL
	} op_t;

	typedef struct packed {
		logic        action;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [15:0] route_metric;
		logic [7:0]  hop_tag;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_network;
		logic [5:0]  found_prefix;
		logic [15:0] found_metric;
		logic [7:0]  found_tag;
	} resp_t;

	// request travelling down the chain of route cells
	typedef struct packed {
		logic             valid;
		op_t              op;
		logic [CNT_W-1:0] slot;
		logic [31:0]      addr;
		logic [5:0]       pfx;
		logic [15:0]      cost;
		logic [7:0]       tag;
		logic             have;
		logic [31:0]      best_net;
		logic [5:0]       best_pfx;
		logic [15:0]      best_cost;
		logic [7:0]       best_tag;
	} chain_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		m = '0;
		for (int b = 0; b < 32; b++) begin
			if (32 - b <= int'(len)) begin
				m[b] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* src/lpr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpr_cell #(
	parameter int IDX = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire lpr_pkg::chain_t chain_in,
	output lpr_pkg::chain_t     chain_out
);
	import lpr_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic        valid_q;
	chain_t      chain_q;
	chain_t      nxt;
	logic [31:0] net_q;
	logic [5:0]  pfx_q;
	logic [15:0] cost_q;
	logic [7:0]  tag_q;
	logic        wr;
	logic        hit;
	logic        better;

	assign wr = advance && chain_in.valid && chain_in.op == OP_ADD && chain_in.slot == IDX_C;

	// route held here takes part only if it was stored before the lookup entered
	assign hit = chain_in.op == OP_LOOKUP && IDX_C < chain_in.slot
		&& ((chain_in.addr ^ net_q) & prefix_mask(pfx_q)) == 32'd0;
	assign better = !chain_in.have || pfx_q > chain_in.best_pfx
		|| (pfx_q == chain_in.best_pfx && cost_q < chain_in.best_cost);

	always_comb begin
		nxt = chain_in;
		if (hit && better) begin
			nxt.have      = 1'b1;
			nxt.best_net  = net_q;
			nxt.best_pfx  = pfx_q;
			nxt.best_cost = cost_q;
			nxt.best_tag  = tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= chain_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chain_q <= nxt;
		end
		if (wr) begin
			net_q  <= chain_in.addr;
			pfx_q  <= chain_in.pfx;
			cost_q <= chain_in.cost;
			tag_q  <= chain_in.tag;
		end
	end

	always_comb begin
		chain_out       = chain_q;
		chain_out.valid = valid_q;
	end

endmodule

`default_nettype wire

/* src/longest_prefix_route_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none
// a request passes the route cells in order, each cell registering it, before its response is valid
// throughput: one request per cycle; the whole cell chain stalls while a response waits
// adds and lookups pass the cells in order, so a lookup sees every earlier add
// reset (arst_n low, asynchronous): route count cleared and the chain emptied;
// stored routes are left as they are and are read only below the count

module longest_prefix_route_lookup #(
	parameter int NUM_ROUTES = lpr_pkg::NUM_ROUTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire lpr_pkg::req_t req,
	output logic               resp_valid,
	input  wire logic          resp_ready,
	output lpr_pkg::resp_t     resp
);
	import lpr_pkg::*;

	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(NUM_ROUTES);

	logic             advance;
	logic             accept;
	logic [CNT_W-1:0] count_q;
	chain_t           entry;
	chain_t           chain [NUM_ROUTES+1];
	chain_t           tail;

	// whole chain moves when the output stage is free or being emptied
	assign tail       = chain[NUM_ROUTES];
	assign advance    = !tail.valid || resp_ready;
	assign req_ready  = advance;
	assign accept     = req_valid && req_ready;
	assign resp_valid = tail.valid;

	// classify the request at the head; an add gets its slot from the route count,
	// a lookup carries the count so that cells above it stay out of the search
	always_comb begin
		entry           = '0;
		entry.valid     = req_valid;
		entry.addr      = req.address;
		entry.pfx       = req.prefix_len;
		entry.cost      = req.route_metric;
		entry.tag       = req.hop_tag;
		entry.slot      = count_q;
		if (req.action == ACT_LOOKUP) begin
			entry.op = OP_LOOKUP;
		end else if (req.prefix_len > MAX_PREFIX) begin
			entry.op = OP_BADPFX;
		end else if (count_q >= FULL_C) begin
			entry.op = OP_FULL;
		end else begin
			entry.op = OP_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && entry.op == OP_ADD) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign chain[0] = entry;

	// one cell per route, each holding its route and passing the request on
	for (genvar g = 0; g < NUM_ROUTES; g++) begin : g_cell
		lpr_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.chain_in (chain[g]),
			.chain_out(chain[g+1])
		);
	end

	// response built from the last cell
	always_comb begin
		resp = '0;
		unique case (tail.op)
			OP_ADD:    resp.status = ST_ADDED;
			OP_BADPFX: resp.status = ST_BADPFX;
			OP_FULL:   resp.status = ST_FULL;
			OP_LOOKUP: begin
				if (tail.have) begin
					resp.status        = ST_FOUND;
					resp.found_network = tail.best_net;
					resp.found_prefix  = tail.best_pfx;
					resp.found_metric  = tail.best_cost;
					resp.found_tag     = tail.best_tag;
				end else begin
					resp.status = ST_NONE;
				end
			end
			default:   resp.status = ST_NONE;
		endcase
	end

`ifndef SYNTHESIS
	// the route count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("route count beyond table size");

	// the count moves only on an accepted add that found room
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && entry.op == OP_ADD) |=> $stable(count_q))
		else $error("route count moved without an add");

	// a found route always has a legal prefix length
	a_found_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && resp.status == ST_FOUND |-> resp.found_prefix <= MAX_PREFIX)
		else $error("found route with bad prefix");

	// a full or rejected add never writes a cell, so a full response means the table is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && resp.status == ST_FULL |-> count_q == FULL_C)
		else $error("full status with room in the table");
`endif

endmodule

`default_nettype wire
